>>> src/q12sr_pkg.sv
// ----------------------------------------------------------------------------
// Q12 square root search package
// Widths of the channel payloads and the command and status bundles that
// pass between the search controller and its datapath.
// ----------------------------------------------------------------------------
package q12sr_pkg;

    // Payload widths of the input and result items.
    localparam int VALUE_W = 20;
    localparam int ROOT_W  = 23;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // Capture a new input and set up the search bounds.
        logic mul;       // Square the current candidate.
        logic step;      // Compare the square and move one bound.
        logic out_load;  // Move the finished root into the output register.
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;      // The current compare ends the search.
    } t_status;

endpackage

>>> src/q12sr_if.sv
// ----------------------------------------------------------------------------
// Q12 square root search channels
// Valid/ready channels for the input value and the resulting root.
// ----------------------------------------------------------------------------
interface q12sr_in_if;
    logic                          valid;
    logic                          ready;
    logic [q12sr_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface q12sr_out_if;
    logic                         valid;
    logic                         ready;
    logic [q12sr_pkg::ROOT_W-1:0] root;

    modport source (output valid, output root, input ready);
    modport sink   (input valid, input root, output ready);
endinterface

>>> src/q12sr_ctrl.sv
// ----------------------------------------------------------------------------
// Q12 square root search controller
// Sequences one search: load, then alternating square and compare cycles,
// then hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module q12sr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output q12sr_pkg::t_cmd    o_cmd,
    input  q12sr_pkg::t_status i_status
);
    import q12sr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_xfer;
    logic       out_free;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.step = 1'b1;
                n_state    = i_status.done ? S_WAIT : S_MUL;
            end
            S_WAIT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The output is valid from its load until the sink takes the transfer.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> src/q12sr_dp.sv
// ----------------------------------------------------------------------------
// Q12 square root search datapath
// Holds the scaled target, the search bounds and the candidate, squares the
// candidate into a registered product, then compares and moves a bound.
// ----------------------------------------------------------------------------
module q12sr_dp #(
    parameter int INPUT_BITS = 20,
    parameter int FRAC_BITS  = 12
) (
    input  logic                          i_clk,
    input  q12sr_pkg::t_cmd               i_cmd,
    output q12sr_pkg::t_status            o_status,
    input  logic [q12sr_pkg::VALUE_W-1:0] i_value,
    output logic [q12sr_pkg::ROOT_W-1:0]  o_root
);
    import q12sr_pkg::*;

    // Target width, bound width (holds target plus one), product and
    // scaled-square widths.
    localparam int TW    = INPUT_BITS + FRAC_BITS;
    localparam int BW    = TW + 1;
    localparam int PW    = 2 * TW;
    localparam int QW    = PW - FRAC_BITS;
    localparam int EXT_W = BW + ROOT_W;

    logic [TW-1:0]     r_target;
    logic [BW-1:0]     r_low;
    logic [BW-1:0]     r_high;
    logic [TW-1:0]     r_mid;
    logic [PW-1:0]     r_prod;
    logic [BW-1:0]     r_root;
    logic [ROOT_W-1:0] r_out_root;

    logic [INPUT_BITS-1:0] x;
    logic [TW-1:0]         target_in;
    logic [QW-1:0]         q;
    logic [QW-1:0]         target_ext;
    logic                  eq;
    logic                  gt;
    logic [BW-1:0]         mid_ext;
    logic [TW-1:0]         mid_dec;
    logic [BW-1:0]         mid_inc;
    logic [BW:0]           sum_gt;
    logic [BW:0]           sum_lt;
    logic                  more_gt;
    logic                  more_lt;
    logic                  done;
    logic [BW-1:0]         root_sel;
    logic [EXT_W-1:0]      root_ext;

    // Scale the input to the target.
    assign x         = i_value[INPUT_BITS-1:0];
    assign target_in = {x, {FRAC_BITS{1'b0}}};

    // Compare the scaled square against the target.
    assign q          = r_prod[PW-1:FRAC_BITS];
    assign target_ext = {{(QW-TW){1'b0}}, r_target};
    assign eq         = (q == target_ext);
    assign gt         = (q > target_ext);

    // Both possible bound moves, their next midpoints and loop tests.
    assign mid_ext = {1'b0, r_mid};
    assign mid_dec = r_mid - 1'b1;
    assign mid_inc = mid_ext + 1'b1;
    assign sum_gt  = {1'b0, r_low} + {2'b00, mid_dec};
    assign sum_lt  = {1'b0, mid_inc} + {1'b0, r_high};
    assign more_gt = (r_low < mid_ext);
    assign more_lt = (mid_ext < r_high);

    assign done          = eq || (gt ? !more_gt : !more_lt);
    assign o_status.done = done;

    // Exact hit returns the candidate, otherwise the upper bound after the move.
    always_comb begin
        if (eq) begin
            root_sel = mid_ext;
        end else if (gt) begin
            root_sel = {1'b0, mid_dec};
        end else begin
            root_sel = r_high;
        end
    end

    // Search registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target <= target_in;
            r_low    <= '0;
            r_high   <= {1'b0, target_in};
            r_mid    <= target_in >> 1;
        end else if (i_cmd.step) begin
            if (gt) begin
                r_high <= {1'b0, mid_dec};
                r_mid  <= sum_gt[TW:1];
            end else begin
                r_low <= mid_inc;
                r_mid <= sum_lt[TW:1];
            end
            if (done) begin
                r_root <= root_sel;
            end
        end
    end

    // Square of the candidate.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= r_mid * r_mid;
        end
    end

    // Output payload register.
    assign root_ext = {{ROOT_W{1'b0}}, r_root};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_root <= root_ext[ROOT_W-1:0];
        end
    end

    assign o_root = r_out_root;

endmodule

>>> src/q12_square_root_search.sv
// ----------------------------------------------------------------------------
// Q12 square root search
// Square root of an unsigned integer in Q10.12 by binary search.
// ----------------------------------------------------------------------------
// The block takes one unsigned value x, forms the target T = x * 2^FRAC_BITS
// and binary-searches a candidate over [0, T] until the candidate's square,
// scaled down by 2^FRAC_BITS, equals T or the bounds cross; the root comes
// out with FRAC_BITS fraction bits. Each probe squares the candidate in the
// multiplier, then compares the scaled square and updates a bound. A search
// needs up to INPUT_BITS + FRAC_BITS probes, and its result may then wait
// for the output register to free. One item is in work at a time; a new item
// is taken as soon as the previous result has been moved into the output
// register, even if that result is still waiting for its transfer.
module q12_square_root_search #(
    parameter int INPUT_BITS = 20,
    parameter int FRAC_BITS  = 12
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    q12sr_in_if.sink    i_in,
    q12sr_out_if.source o_out
);
    import q12sr_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Controller.
    q12sr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // Datapath.
    q12sr_dp #(
        .INPUT_BITS (INPUT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .o_status (status),
        .i_value  (i_in.value),
        .o_root   (o_out.root)
    );

endmodule

>>> src/q12sr_checker.sv
// ----------------------------------------------------------------------------
// Q12 square root search checker
// Port-level checks of the search block, bound to its top level.
// ----------------------------------------------------------------------------
module q12sr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [q12sr_pkg::ROOT_W-1:0]  i_out_root
);
    import q12sr_pkg::*;

    localparam logic [ROOT_W-1:0] ROOT_MAX = ROOT_W'(23'h400000);

    // A stalled result keeps its valid and its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_root))
        else $error("stalled result changed");

    // Only one search runs at a time: a transfer in closes the input.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while a search runs");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // The root of a 20-bit value never exceeds 1024 in Q12.
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_root <= ROOT_MAX)
        else $error("root out of range");

endmodule

bind q12_square_root_search q12sr_checker u_q12sr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_root  (o_out.root)
);
